// ===== hdl/ttb_pkg.sv =====
// Package for the text terminal buffer: character codes, default grid size,
// controller states and the command and status structs.
// No dependencies; ttb_ctrl, ttb_dp, the top level and the bench use it.
package ttb_pkg;

    // Field widths of the request and result ports.
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;

    // Default grid size.
    localparam int DEF_NUM_ROWS = 20;
    localparam int DEF_NUM_COLS = 60;

    // Character codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_RDATA,
        ST_PUT,
        ST_SCROLL,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic cnt_clr;
        logic cnt_inc;
        logic clr_en;
        logic put_en;
        logic scr_en;
        logic rd_cap;
        logic fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_read;
        logic init_last;
        logic need_scroll;
        logic scr_last;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/ttb_ram.sv =====
// Generic single-port RAM with a registered read.
// No dependencies.
module ttb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1200,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read in the cycle of a write returns the old contents; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ttb_ctrl.sv =====
// Controller state machine of the text terminal buffer.
// Depends on ttb_pkg for the state type and the command and status structs.
module ttb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ttb_pkg::t_sts i_sts,
    output ttb_pkg::t_cmd o_cmd
);

    ttb_pkg::t_state r_state;
    ttb_pkg::t_state n_state;
    logic            w_accept;

    assign o_in_stall = (r_state != ttb_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttb_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttb_pkg::ST_INIT: begin
                if (i_sts.init_last) n_state = ttb_pkg::ST_IDLE;
            end
            ttb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_sts.req_read ? ttb_pkg::ST_READ : ttb_pkg::ST_PUT;
                end
            end
            ttb_pkg::ST_READ: begin
                n_state = ttb_pkg::ST_RDATA;
            end
            ttb_pkg::ST_RDATA: begin
                n_state = ttb_pkg::ST_DONE;
            end
            ttb_pkg::ST_PUT: begin
                n_state = i_sts.need_scroll ? ttb_pkg::ST_SCROLL : ttb_pkg::ST_DONE;
            end
            ttb_pkg::ST_SCROLL: begin
                if (i_sts.scr_last) n_state = ttb_pkg::ST_DONE;
            end
            ttb_pkg::ST_DONE: begin
                if (i_sts.out_free) n_state = ttb_pkg::ST_IDLE;
            end
            default: begin
                n_state = ttb_pkg::ST_INIT;
            end
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ttb_pkg::ST_INIT: begin
                o_cmd.clr_en  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            ttb_pkg::ST_IDLE: begin
                o_cmd.load_in = w_accept;
            end
            ttb_pkg::ST_READ: begin
            end
            ttb_pkg::ST_RDATA: begin
                o_cmd.rd_cap = 1'b1;
            end
            ttb_pkg::ST_PUT: begin
                o_cmd.put_en  = 1'b1;
                o_cmd.cnt_clr = 1'b1;
            end
            ttb_pkg::ST_SCROLL: begin
                o_cmd.scr_en  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            ttb_pkg::ST_DONE: begin
                o_cmd.fin = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    // The result register is loaded only when it is free.
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_sts.out_free)
        else $error("result loaded while the previous one is still held");

    // The row clear sweep ends in the result state.
    a_scroll_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttb_pkg::ST_SCROLL && i_sts.scr_last) |=> (r_state == ttb_pkg::ST_DONE))
        else $error("row clear sweep did not end in the result state");

    // A put goes either to the row clear sweep or straight to the result state.
    a_put_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttb_pkg::ST_PUT)
            |=> (r_state == ttb_pkg::ST_SCROLL || r_state == ttb_pkg::ST_DONE))
        else $error("put did not move on to the sweep or the result state");

endmodule

// ===== hdl/ttb_dp.sv =====
// Datapath of the text terminal buffer: cursor, top row offset, sweep counter,
// cell RAM address and data, and the result register.
// Depends on ttb_pkg and instantiates ttb_ram.
module ttb_dp #(
    parameter int NUM_ROWS = ttb_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLS = ttb_pkg::DEF_NUM_COLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ttb_pkg::t_cmd                i_cmd,
    output ttb_pkg::t_sts                o_sts,
    input  logic                         i_mode,
    input  logic [ttb_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [ttb_pkg::ROW_W-1:0]    i_read_row,
    input  logic [ttb_pkg::COL_W-1:0]    i_read_col,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ttb_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [ttb_pkg::ROW_W-1:0]    o_cur_row,
    output logic [ttb_pkg::COL_W-1:0]    o_cur_col,
    output logic                         o_scrolled
);

    localparam int RW    = $clog2(NUM_ROWS);
    localparam int CW    = $clog2(NUM_COLS);
    localparam int DEPTH = NUM_ROWS * NUM_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] COLS_A = AW'(NUM_COLS);

    // Control registers.
    logic [AW-1:0] r_cnt;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_top;
    logic          r_out_valid;

    // Latched request and pending result.
    logic [ttb_pkg::CHAR_W-1:0] r_char;
    logic [ttb_pkg::ROW_W-1:0]  r_rrow;
    logic [ttb_pkg::COL_W-1:0]  r_rcol;
    logic [ttb_pkg::CHAR_W-1:0] r_cell;
    logic                       r_scr;

    // Result register.
    logic [ttb_pkg::CHAR_W-1:0] r_o_cell;
    logic [ttb_pkg::ROW_W-1:0]  r_o_row;
    logic [ttb_pkg::COL_W-1:0]  r_o_col;
    logic                       r_o_scr;

    logic [CW:0]                w_col_n;
    logic [RW:0]                w_row_n;
    logic                       w_put_wr;
    logic                       w_need_scroll;
    logic                       w_rd_ok;
    logic [RW-1:0]              w_rrow_l;
    logic [CW-1:0]              w_rcol_l;
    logic [AW-1:0]              w_rd_addr;
    logic [AW-1:0]              w_addr;
    logic                       w_we;
    logic [ttb_pkg::CHAR_W-1:0] w_wdata;
    logic [ttb_pkg::CHAR_W-1:0] w_rdata;
    logic                       w_scr_last;

    // Physical row of a logical row in the circular row store.
    function automatic logic [RW-1:0] f_phys(input logic [RW-1:0] top,
                                             input logic [RW-1:0] lrow);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, lrow};
        if (s >= (RW+1)'(NUM_ROWS)) begin
            s = s - (RW+1)'(NUM_ROWS);
        end
        return s[RW-1:0];
    endfunction

    // Cursor update of a put request.
    always_comb begin
        w_col_n  = {1'b0, r_col};
        w_row_n  = {1'b0, r_row};
        w_put_wr = 1'b0;
        if (r_char == ttb_pkg::CH_NEWLINE) begin
            w_col_n = '0;
            w_row_n = w_row_n + 1'b1;
        end else if (r_char == ttb_pkg::CH_BACKSPACE) begin
            if (r_col != '0) begin
                w_col_n = w_col_n - 1'b1;
            end
        end else begin
            w_put_wr = 1'b1;
            w_col_n  = w_col_n + 1'b1;
        end
        if (w_col_n >= (CW+1)'(NUM_COLS)) begin
            w_col_n = '0;
            w_row_n = w_row_n + 1'b1;
        end
        w_need_scroll = (w_row_n >= (RW+1)'(NUM_ROWS));
        if (w_need_scroll) begin
            w_row_n = (RW+1)'(NUM_ROWS - 1);
        end
    end

    // Read address; a cell outside the grid reads as zero.
    assign w_rd_ok   = (32'(r_rrow) < NUM_ROWS) && (32'(r_rcol) < NUM_COLS);
    assign w_rrow_l  = RW'(r_rrow);
    assign w_rcol_l  = CW'(r_rcol);
    assign w_rd_addr = w_rd_ok ? (AW'(f_phys(r_top, w_rrow_l)) * COLS_A + AW'(w_rcol_l)) : '0;

    assign w_scr_last = (r_cnt[CW-1:0] == CW'(NUM_COLS - 1));

    // RAM port: clearing pass, row clear, character write, or cell read.
    always_comb begin
        w_we    = 1'b0;
        w_wdata = ttb_pkg::CH_SPACE;
        w_addr  = w_rd_addr;
        if (i_cmd.clr_en) begin
            w_we   = 1'b1;
            w_addr = r_cnt;
        end else if (i_cmd.scr_en) begin
            w_we   = 1'b1;
            w_addr = AW'(r_top) * COLS_A + AW'(r_cnt[CW-1:0]);
        end else if (i_cmd.put_en) begin
            w_we    = w_put_wr;
            w_wdata = r_char;
            w_addr  = AW'(f_phys(r_top, r_row)) * COLS_A + AW'(r_col);
        end
    end

    ttb_ram #(
        .WIDTH (ttb_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Cursor, top row, sweep counter and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.put_en) begin
                r_row <= w_row_n[RW-1:0];
                r_col <= w_col_n[CW-1:0];
            end
            if (i_cmd.scr_en && w_scr_last) begin
                r_top <= (r_top == RW'(NUM_ROWS - 1)) ? '0 : r_top + 1'b1;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request latch, pending result and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_char <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
        if (i_cmd.put_en) begin
            r_cell <= '0;
            r_scr  <= w_need_scroll;
        end else if (i_cmd.rd_cap) begin
            r_cell <= w_rd_ok ? w_rdata : '0;
            r_scr  <= 1'b0;
        end
        if (i_cmd.fin) begin
            r_o_cell <= r_cell;
            r_o_row  <= ttb_pkg::ROW_W'(r_row);
            r_o_col  <= ttb_pkg::COL_W'(r_col);
            r_o_scr  <= r_scr;
        end
    end

    assign o_sts.req_read    = i_mode;
    assign o_sts.init_last   = (r_cnt == AW'(DEPTH - 1));
    assign o_sts.need_scroll = w_need_scroll;
    assign o_sts.scr_last    = w_scr_last;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_cell_char = r_o_cell;
    assign o_cur_row   = r_o_row;
    assign o_cur_col   = r_o_col;
    assign o_scrolled  = r_o_scr;

    // The cursor stays inside the grid.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < NUM_COLS)
        else $error("cursor column outside the grid");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < NUM_ROWS)
        else $error("cursor row outside the grid");

    // The top row offset names a physical row.
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_top) < NUM_ROWS)
        else $error("top row offset outside the grid");

endmodule

// ===== hdl/text_terminal_buffer.sv =====
// Text terminal buffer: a read request passes the controller states READ, RDATA and
// DONE, a put PUT and DONE, a put that scrolls PUT, SCROLL and DONE; DONE waits out
// any output stall. One request is in work at a time and a new one is taken only in
// IDLE; the single-port cell RAM and the row clear sweep set that.
// After reset a clearing pass fills NUM_ROWS * NUM_COLS cells (1200 by
// default) with spaces, one per cycle, with the request stall held high.
module text_terminal_buffer #(
    parameter int NUM_ROWS = ttb_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLS = ttb_pkg::DEF_NUM_COLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_mode,
    input  logic [ttb_pkg::CHAR_W-1:0] i_char_code,
    input  logic [ttb_pkg::ROW_W-1:0]  i_read_row,
    input  logic [ttb_pkg::COL_W-1:0]  i_read_col,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ttb_pkg::CHAR_W-1:0] o_cell_char,
    output logic [ttb_pkg::ROW_W-1:0]  o_cur_row,
    output logic [ttb_pkg::COL_W-1:0]  o_cur_col,
    output logic                       o_scrolled
);

    ttb_pkg::t_cmd w_cmd;
    ttb_pkg::t_sts w_sts;

    // Controller.
    ttb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath with the cell RAM.
    ttb_dp #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cell_char (o_cell_char),
        .o_cur_row   (o_cur_row),
        .o_cur_col   (o_cur_col),
        .o_scrolled  (o_scrolled)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for text_terminal_buffer: a directed table, then random put and
// read requests, each checked against its typed result or an in-bench screen model.
// Depends on hdl/ttb_pkg.sv and hdl/text_terminal_buffer.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_W    = ttb_pkg::CHAR_W;
    localparam int ROW_W     = ttb_pkg::ROW_W;
    localparam int COL_W     = ttb_pkg::COL_W;
    localparam int NUM_ROWS  = ttb_pkg::DEF_NUM_ROWS;
    localparam int NUM_COLS  = ttb_pkg::DEF_NUM_COLS;
    localparam int RAND_REQS = 950;
    localparam int IDLE_PCT  = 21;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = ttb_pkg::CH_BACKSPACE;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = ttb_pkg::CH_NEWLINE;
    localparam logic [CHAR_W-1:0] CH_SPACE     = ttb_pkg::CH_SPACE;

    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ROW_W-1:0]  cur_row;
        logic [COL_W-1:0]  cur_col;
        logic              scrolled;
    } t_screen_result;

    typedef struct packed {
        logic              mode;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rrow;
        logic [COL_W-1:0]  rcol;
        logic [7:0]        reps;
        logic              typed;
        t_screen_result    res;
    } t_term_vector;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_mode = MODE_PUT;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic [ROW_W-1:0]  i_read_row = '0;
    logic [COL_W-1:0]  i_read_col = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [CHAR_W-1:0] o_cell_char;
    logic [ROW_W-1:0]  o_cur_row;
    logic [COL_W-1:0]  o_cur_col;
    logic              o_scrolled;

    // Screen model state.
    logic [CHAR_W-1:0] screen_cells [NUM_ROWS*NUM_COLS];
    int                model_row;
    int                model_col;
    int                top_row;

    t_screen_result    results_due[$];
    int                fail_count = 0;
    bit                calm = 1'b0;

    // Directed requests: typed results where they follow at a glance.
    t_term_vector directed_rows [25] = '{
        '{MODE_READ, 8'h00,        5'd0,  6'd0,  8'd1,  1'b1, '{8'h20, 5'd0,  6'd0, 1'b0}},
        '{MODE_READ, 8'h00,        5'd19, 6'd59, 8'd1,  1'b1, '{8'h20, 5'd0,  6'd0, 1'b0}},
        '{MODE_READ, 8'h00,        5'd20, 6'd0,  8'd1,  1'b1, '{8'h00, 5'd0,  6'd0, 1'b0}},
        '{MODE_READ, 8'h00,        5'd0,  6'd60, 8'd1,  1'b1, '{8'h00, 5'd0,  6'd0, 1'b0}},
        '{MODE_READ, 8'hff,        5'd31, 6'd63, 8'd1,  1'b1, '{8'h00, 5'd0,  6'd0, 1'b0}},
        '{MODE_PUT,  CH_BACKSPACE, 5'd31, 6'd63, 8'd1,  1'b1, '{8'h00, 5'd0,  6'd0, 1'b0}},
        '{MODE_PUT,  8'h41,        5'd0,  6'd0,  8'd1,  1'b1, '{8'h00, 5'd0,  6'd1, 1'b0}},
        '{MODE_PUT,  8'hff,        5'd0,  6'd0,  8'd1,  1'b1, '{8'h00, 5'd0,  6'd2, 1'b0}},
        '{MODE_PUT,  8'h00,        5'd0,  6'd0,  8'd1,  1'b1, '{8'h00, 5'd0,  6'd3, 1'b0}},
        '{MODE_READ, 8'h00,        5'd0,  6'd0,  8'd1,  1'b1, '{8'h41, 5'd0,  6'd3, 1'b0}},
        '{MODE_READ, 8'h00,        5'd0,  6'd1,  8'd1,  1'b1, '{8'hff, 5'd0,  6'd3, 1'b0}},
        '{MODE_READ, 8'h00,        5'd0,  6'd2,  8'd1,  1'b1, '{8'h00, 5'd0,  6'd3, 1'b0}},
        '{MODE_PUT,  CH_BACKSPACE, 5'd0,  6'd0,  8'd1,  1'b1, '{8'h00, 5'd0,  6'd2, 1'b0}},
        '{MODE_PUT,  CH_NEWLINE,   5'd0,  6'd0,  8'd1,  1'b1, '{8'h00, 5'd1,  6'd0, 1'b0}},
        '{MODE_PUT,  8'h7e,        5'd0,  6'd0,  8'd59, 1'b0, '0},
        '{MODE_PUT,  8'h2a,        5'd0,  6'd0,  8'd1,  1'b1, '{8'h00, 5'd2,  6'd0, 1'b0}},
        '{MODE_PUT,  CH_NEWLINE,   5'd0,  6'd0,  8'd17, 1'b0, '0},
        '{MODE_PUT,  CH_NEWLINE,   5'd0,  6'd0,  8'd1,  1'b1, '{8'h00, 5'd19, 6'd0, 1'b1}},
        '{MODE_READ, 8'h00,        5'd0,  6'd1,  8'd1,  1'b1, '{8'h7e, 5'd19, 6'd0, 1'b0}},
        '{MODE_READ, 8'h00,        5'd19, 6'd0,  8'd1,  1'b1, '{8'h20, 5'd19, 6'd0, 1'b0}},
        '{MODE_PUT,  8'h31,        5'd0,  6'd0,  8'd59, 1'b0, '0},
        '{MODE_PUT,  8'h32,        5'd0,  6'd0,  8'd1,  1'b1, '{8'h00, 5'd19, 6'd0, 1'b1}},
        '{MODE_READ, 8'h00,        5'd18, 6'd59, 8'd1,  1'b1, '{8'h32, 5'd19, 6'd0, 1'b0}},
        '{MODE_READ, 8'h00,        5'd18, 6'd0,  8'd1,  1'b1, '{8'h31, 5'd19, 6'd0, 1'b0}},
        '{MODE_READ, 8'h00,        5'd17, 6'd59, 8'd1,  1'b1, '{8'h20, 5'd19, 6'd0, 1'b0}}
    };

    text_terminal_buffer #(
        .NUM_ROWS(NUM_ROWS),
        .NUM_COLS(NUM_COLS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_char_code(i_char_code),
        .i_read_row (i_read_row),
        .i_read_col (i_read_col),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cell_char(o_cell_char),
        .o_cur_row  (o_cur_row),
        .o_cur_col  (o_cur_col),
        .o_scrolled (o_scrolled)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clear the screen model to its state after reset.
    function automatic void clear_screen();
        foreach (screen_cells[i]) screen_cells[i] = CH_SPACE;
        model_row = 0;
        model_col = 0;
        top_row   = 0;
    endfunction

    // Apply one request to the screen model and return the result it produces.
    function automatic t_screen_result apply_to_screen(input logic mode,
                                                       input logic [CHAR_W-1:0] ch,
                                                       input logic [ROW_W-1:0] rrow,
                                                       input logic [COL_W-1:0] rcol);
        t_screen_result res;
        int             prow;
        res = '0;
        if (mode == MODE_READ) begin
            if (int'(rrow) < NUM_ROWS && int'(rcol) < NUM_COLS) begin
                prow = (top_row + int'(rrow)) % NUM_ROWS;
                res.cell_char = screen_cells[prow*NUM_COLS + int'(rcol)];
            end
        end else begin
            if (ch == CH_NEWLINE) begin
                model_col = 0;
                model_row++;
            end else if (ch == CH_BACKSPACE) begin
                if (model_col > 0) model_col--;
            end else begin
                prow = (top_row + model_row) % NUM_ROWS;
                screen_cells[prow*NUM_COLS + model_col] = ch;
                model_col++;
            end
            if (model_col >= NUM_COLS) begin
                model_col = 0;
                model_row++;
            end
            // The old top row comes back as the blank bottom row.
            if (model_row >= NUM_ROWS) begin
                for (int c = 0; c < NUM_COLS; c++) begin
                    screen_cells[top_row*NUM_COLS + c] = CH_SPACE;
                end
                top_row   = (top_row + 1) % NUM_ROWS;
                model_row = NUM_ROWS - 1;
                res.scrolled = 1'b1;
            end
        end
        res.cur_row = model_row[ROW_W-1:0];
        res.cur_col = model_col[COL_W-1:0];
        return res;
    endfunction

    // Present one request, hold it until it is taken, then record its result.
    task automatic send_request(input logic mode, input logic [CHAR_W-1:0] ch,
                                input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol,
                                input logic typed, input t_screen_result typed_res);
        t_screen_result res;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_char_code <= ch;
        i_read_row  <= rrow;
        i_read_col  <= rcol;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = apply_to_screen(mode, ch, rrow, rcol);
        results_due.push_back(typed ? typed_res : res);
    endtask

    // Receiver stall, off during the calm stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Compare every accepted result with the oldest one still due.
    always @(posedge i_clk) begin
        t_screen_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $error("result with none due: cell_char %0h cur_row %0d cur_col %0d",
                       o_cell_char, o_cur_row, o_cur_col);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                if (o_cell_char !== want.cell_char) begin
                    $error("cell_char: expected %0h, got %0h", want.cell_char, o_cell_char);
                    fail_count++;
                end
                if (o_cur_row !== want.cur_row) begin
                    $error("cur_row: expected %0d, got %0d", want.cur_row, o_cur_row);
                    fail_count++;
                end
                if (o_cur_col !== want.cur_col) begin
                    $error("cur_col: expected %0d, got %0d", want.cur_col, o_cur_col);
                    fail_count++;
                end
                if (o_scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, o_scrolled);
                    fail_count++;
                end
            end
        end
    end

    // Reset, directed table, random requests, drain.
    initial begin
        logic              mode;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rrow;
        logic [COL_W-1:0]  rcol;
        int                pick;

        clear_screen();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            for (int n = 0; n < int'(directed_rows[i].reps); n++) begin
                send_request(directed_rows[i].mode, directed_rows[i].ch,
                             directed_rows[i].rrow, directed_rows[i].rcol,
                             directed_rows[i].typed, directed_rows[i].res);
            end
        end

        // Mostly puts so the screen fills and scrolls; some reads land off the grid.
        for (int k = 0; k < RAND_REQS; k++) begin
            calm = (k >= 300 && k < 500);
            mode = ($urandom_range(0, 99) < 35) ? MODE_READ : MODE_PUT;
            pick = int'($urandom_range(0, 99));
            if (pick < 12) ch = CH_NEWLINE;
            else if (pick < 20) ch = CH_BACKSPACE;
            else ch = CHAR_W'($urandom_range(0, 255));
            if ($urandom_range(0, 4) != 0) begin
                rrow = ROW_W'($urandom_range(0, NUM_ROWS - 1));
                rcol = COL_W'($urandom_range(0, NUM_COLS - 1));
            end else begin
                rrow = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
                rcol = COL_W'($urandom_range(0, (1 << COL_W) - 1));
            end
            send_request(mode, ch, rrow, rcol, 1'b0, '0);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (NUM_COLS + 20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("text_terminal_buffer verification clean");
        end else begin
            $display("text_terminal_buffer verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("text_terminal_buffer verification failed");
        $finish;
    end

endmodule
